// File: rtl/fptm_pkg.sv
// Shared types and constants for the frame pacing and timing monitor.
// No dependencies; imported by fptm_div, frame_pacing_timing_monitor, fptm_checker and tb.
package fptm_pkg;

	localparam int TICK_W    = 32;   // millisecond tick width
	localparam int TIME_W    = 24;   // Q16.8 millisecond time width
	localparam int FRAC_W    = 8;    // fraction bits of Q16.8
	localparam int MS_W      = 16;   // whole millisecond bits of Q16.8
	localparam int TARGET_W  = 18;   // target frame time register width
	localparam int DELAY_W   = 10;   // whole millisecond delay width
	localparam int COUNT_W   = 32;   // frame counter width
	localparam int FPS_NUM_W = 26;   // width of the fps numerator

	// 1000 ms expressed in Q16.8, then scaled by 256 again for a Q16.8 quotient.
	localparam logic [FPS_NUM_W-1:0] FPS_NUM      = 26'd65536000;
	localparam logic [TIME_W-1:0]    TIME_MAX     = 24'hFFFFFF;
	localparam logic [TARGET_W-1:0]  TARGET_RESET = 18'd4267;
	localparam logic [MS_W-1:0]      MS_MAX       = 16'hFFFF;

	// Status of the serial divider as seen by its user.
	typedef struct packed {
		logic done;
	} div_status_t;

endpackage

// File: rtl/fptm_div.sv
// Bit-serial restoring divider: one quotient bit per clock cycle.
// Depends on fptm_pkg for the status struct.
module fptm_div import fptm_pkg::*; #(
	parameter int N_W = 30,
	parameter int D_W = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N_W-1:0] dividend,
	input  logic [D_W-1:0] divisor,
	output div_status_t    status,
	output logic [N_W-1:0] quotient
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [N_W-1:0]   num_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [D_W:0]     trial;
	logic             fits;
	logic [D_W:0]     diff;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, num_q[N_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(N_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[N_W-2:0], fits};
			rem_q <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign status.done = done_q;
	assign quotient    = num_q;

endmodule

// File: rtl/frame_pacing_timing_monitor.sv
// Frame pacing and timing monitor: top level with windows, sums and sequencer.
// Depends on fptm_pkg and instantiates the serial divider fptm_div.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+-------------------------------------------------
//  input    | in_valid/in_ready  | frame_start_tick, frame_end_tick
//  output   | out_valid/out_ready| spent_time .. frame_count (ten fields)
//  config   | cfg_we             | cfg_wdata (target frame time, Q16.8 ms)
//
// A frame passes through the idle, calc, sum and done steps while no more than WINDOW
// frames have been seen; after that the serial divider (one quotient bit per cycle)
// also produces the elapsed average and fps, and on a window boundary the spent and
// waiting averages as well.
// Reset clears the sums, counters and held values; the window memories are not
// cleared, a sticky fill flag makes unwritten entries read as zero.
// A new frame is accepted while the previous result still waits in the output
// register; the sequencer stalls only at its last step until that register frees.
module frame_pacing_timing_monitor import fptm_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// Frame transactions in.
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [TICK_W-1:0]   frame_start_tick,
	input  logic [TICK_W-1:0]   frame_end_tick,
	// Result transactions out.
	output logic                out_valid,
	input  logic                out_ready,
	output logic [TIME_W-1:0]   spent_time,
	output logic [TIME_W-1:0]   waiting_time,
	output logic [TIME_W-1:0]   elapsed_time,
	output logic [DELAY_W-1:0]  delay_ms,
	output logic                fps_valid,
	output logic [TIME_W-1:0]   fps_rate,
	output logic [TIME_W-1:0]   avg_elapsed,
	output logic [TIME_W-1:0]   avg_spent,
	output logic [TIME_W-1:0]   avg_waiting,
	output logic [COUNT_W-1:0]  frame_count,
	// Target frame time register.
	input  logic                cfg_we,
	input  logic [TARGET_W-1:0] cfg_wdata
);

	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int SUM_W   = TIME_W + $clog2(WINDOW);
	localparam int DIV_N_W = (SUM_W > FPS_NUM_W) ? SUM_W : FPS_NUM_W;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_CALC = 6'b000010,
		S_SUM  = 6'b000100,
		S_GO   = 6'b001000,
		S_WAIT = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	// Which quotient the divider is currently producing.
	typedef enum logic [1:0] {
		JOB_ELAPSED = 2'd0,
		JOB_FPS     = 2'd1,
		JOB_SPENT   = 2'd2,
		JOB_WAITING = 2'd3
	} job_t;

	state_t state_q;
	job_t   job_q;

	logic [TARGET_W-1:0] target_q;

	// Per-frame working values.
	logic [TIME_W-1:0] spent_q;
	logic [TIME_W-1:0] waiting_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] old_e_q;
	logic [TIME_W-1:0] old_s_q;
	logic [TIME_W-1:0] old_w_q;
	logic              upd_q;
	logic              bnd_q;

	// Running state.
	logic [SUM_W-1:0]   e_sum_q;
	logic [SUM_W-1:0]   s_sum_q;
	logic [SUM_W-1:0]   w_sum_q;
	logic [COUNT_W-1:0] frames_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               full_q;
	logic [TIME_W-1:0]  avg_e_q;
	logic [TIME_W-1:0]  fps_q;
	logic               fps_vld_q;
	logic [TIME_W-1:0]  hold_e_q;
	logic [TIME_W-1:0]  hold_s_q;
	logic [TIME_W-1:0]  hold_w_q;

	// Output register.
	logic               out_vld_q;
	logic [TIME_W-1:0]  o_spent_q;
	logic [TIME_W-1:0]  o_wait_q;
	logic [TIME_W-1:0]  o_elap_q;
	logic [TIME_W-1:0]  o_fps_q;
	logic               o_fps_vld_q;
	logic [TIME_W-1:0]  o_avg_e_q;
	logic [TIME_W-1:0]  o_avg_s_q;
	logic [TIME_W-1:0]  o_avg_w_q;
	logic [COUNT_W-1:0] o_count_q;

	// Ring windows, one entry per slot.
	logic [TIME_W-1:0] e_mem [WINDOW];
	logic [TIME_W-1:0] s_mem [WINDOW];
	logic [TIME_W-1:0] w_mem [WINDOW];

	logic [TICK_W-1:0]  tick_diff;
	logic [MS_W-1:0]    ms_sat;
	logic               pace;
	logic [TIME_W-1:0]  waiting_c;
	logic [TIME_W-1:0]  elapsed_c;
	logic [TIME_W-1:0]  old_e;
	logic [TIME_W-1:0]  old_s;
	logic [TIME_W-1:0]  old_w;
	logic               out_free;
	logic               div_start;
	logic [DIV_N_W-1:0] div_num;
	logic [TIME_W-1:0]  div_den;
	div_status_t        div_stat;
	logic [DIV_N_W-1:0] div_quot;
	logic [TIME_W-1:0]  quot_sat;

	// Frame work time: the tick difference wraps modulo 2^32 and saturates at 65535 ms.
	assign tick_diff = frame_end_tick - frame_start_tick;
	assign ms_sat    = (|tick_diff[TICK_W-1:MS_W]) ? MS_MAX : tick_diff[MS_W-1:0];

	// Pacing pads a short frame up to the target; elapsed then equals the target.
	assign pace      = (target_q != '0) && (spent_q < TIME_W'(target_q));
	assign waiting_c = pace ? TIME_W'(target_q - spent_q[TARGET_W-1:0]) : '0;
	assign elapsed_c = pace ? TIME_W'(target_q) : spent_q;

	// Entries not yet written in the first pass read as zero.
	assign old_e = full_q ? old_e_q : '0;
	assign old_s = full_q ? old_s_q : '0;
	assign old_w = full_q ? old_w_q : '0;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_vld_q || out_ready;

	// The divider serves the three window averages and the fps quotient.
	always_comb begin
		div_num = DIV_N_W'(e_sum_q);
		div_den = TIME_W'(WINDOW);
		case (job_q)
			JOB_ELAPSED: div_num = DIV_N_W'(e_sum_q);
			JOB_FPS: begin
				div_num = DIV_N_W'(FPS_NUM);
				div_den = avg_e_q;
			end
			JOB_SPENT:   div_num = DIV_N_W'(s_sum_q);
			JOB_WAITING: div_num = DIV_N_W'(w_sum_q);
			default:     div_num = DIV_N_W'(e_sum_q);
		endcase
	end

	assign div_start = (state_q == S_GO);

	// A zero average divides to all ones, which saturates like any large quotient.
	assign quot_sat = (|div_quot[DIV_N_W-1:TIME_W]) ? TIME_MAX : div_quot[TIME_W-1:0];

	fptm_div #(
		.N_W(DIV_N_W),
		.D_W(TIME_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.status   (div_stat),
		.quotient (div_quot)
	);

	// Window memories: the old entry is read and the new one written in the same cycle.
	always_ff @(posedge clk) begin
		if (state_q == S_CALC) begin
			old_e_q       <= e_mem[slot_q];
			old_s_q       <= s_mem[slot_q];
			old_w_q       <= w_mem[slot_q];
			e_mem[slot_q] <= elapsed_c;
			s_mem[slot_q] <= spent_q;
			w_mem[slot_q] <= waiting_c;
		end
	end

	// Per-frame payload registers.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			spent_q <= {ms_sat, FRAC_W'(0)};
		end
		if (state_q == S_CALC) begin
			waiting_q <= waiting_c;
			elapsed_q <= elapsed_c;
			upd_q     <= (frames_q > COUNT_W'(WINDOW));
			bnd_q     <= (slot_q == '0);
		end
		if (state_q == S_WAIT && div_stat.done && job_q == JOB_ELAPSED) begin
			avg_e_q <= div_quot[TIME_W-1:0];
		end
		if (state_q == S_DONE && out_free) begin
			o_spent_q   <= spent_q;
			o_wait_q    <= waiting_q;
			o_elap_q    <= elapsed_q;
			o_fps_q     <= fps_q;
			o_fps_vld_q <= fps_vld_q;
			o_avg_e_q   <= hold_e_q;
			o_avg_s_q   <= hold_s_q;
			o_avg_w_q   <= hold_w_q;
			o_count_q   <= frames_q;
		end
	end

	// The result register fills when the sequencer finishes and empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Sequencer, running sums, counters and held results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			job_q     <= JOB_ELAPSED;
			target_q  <= TARGET_RESET;
			e_sum_q   <= '0;
			s_sum_q   <= '0;
			w_sum_q   <= '0;
			frames_q  <= '0;
			slot_q    <= '0;
			full_q    <= 1'b0;
			fps_q     <= '0;
			fps_vld_q <= 1'b0;
			hold_e_q  <= '0;
			hold_s_q  <= '0;
			hold_w_q  <= '0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					e_sum_q  <= e_sum_q - SUM_W'(old_e) + SUM_W'(elapsed_q);
					s_sum_q  <= s_sum_q - SUM_W'(old_s) + SUM_W'(spent_q);
					w_sum_q  <= w_sum_q - SUM_W'(old_w) + SUM_W'(waiting_q);
					frames_q <= frames_q + COUNT_W'(1);
					// The slot follows the counter modulo WINDOW, also across its wrap.
					if (frames_q == '1) begin
						slot_q <= '0;
					end else if (slot_q == SLOT_W'(WINDOW - 1)) begin
						slot_q <= '0;
						full_q <= 1'b1;
					end else begin
						slot_q <= slot_q + SLOT_W'(1);
					end
					job_q   <= JOB_ELAPSED;
					state_q <= upd_q ? S_GO : S_DONE;
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_stat.done) begin
						case (job_q)
							JOB_ELAPSED: begin
								job_q   <= JOB_FPS;
								state_q <= S_GO;
							end
							JOB_FPS: begin
								fps_q     <= quot_sat;
								fps_vld_q <= 1'b1;
								if (bnd_q) begin
									hold_e_q <= avg_e_q;
									job_q    <= JOB_SPENT;
									state_q  <= S_GO;
								end else begin
									state_q <= S_DONE;
								end
							end
							JOB_SPENT: begin
								hold_s_q <= div_quot[TIME_W-1:0];
								job_q    <= JOB_WAITING;
								state_q  <= S_GO;
							end
							JOB_WAITING: begin
								hold_w_q <= div_quot[TIME_W-1:0];
								state_q  <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_vld_q;
	assign spent_time   = o_spent_q;
	assign waiting_time = o_wait_q;
	assign elapsed_time = o_elap_q;
	assign delay_ms     = o_wait_q[FRAC_W +: DELAY_W];
	assign fps_valid    = o_fps_vld_q;
	assign fps_rate     = o_fps_q;
	assign avg_elapsed  = o_avg_e_q;
	assign avg_spent    = o_avg_s_q;
	assign avg_waiting  = o_avg_w_q;
	assign frame_count  = o_count_q;

endmodule

// File: verif/fptm_checker.sv
// Checker for the frame pacing and timing monitor: watches the frame, result and
// target register ports, predicts every result and compares it field by field.
// Depends on fptm_pkg for widths and constants.
module fptm_checker import fptm_pkg::*; #(
	parameter int WINDOW = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [TICK_W-1:0]   frame_start_tick,
	input  logic [TICK_W-1:0]   frame_end_tick,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [TIME_W-1:0]   spent_time,
	input  logic [TIME_W-1:0]   waiting_time,
	input  logic [TIME_W-1:0]   elapsed_time,
	input  logic [DELAY_W-1:0]  delay_ms,
	input  logic                fps_valid,
	input  logic [TIME_W-1:0]   fps_rate,
	input  logic [TIME_W-1:0]   avg_elapsed,
	input  logic [TIME_W-1:0]   avg_spent,
	input  logic [TIME_W-1:0]   avg_waiting,
	input  logic [COUNT_W-1:0]  frame_count,
	input  logic                cfg_we,
	input  logic [TARGET_W-1:0] cfg_wdata,
	output int                  mismatch_count,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [TIME_W-1:0]  spent;
		logic [TIME_W-1:0]  waiting;
		logic [TIME_W-1:0]  elapsed;
		logic [DELAY_W-1:0] delay;
		logic               fps_ok;
		logic [TIME_W-1:0]  fps;
		logic [TIME_W-1:0]  avg_el;
		logic [TIME_W-1:0]  avg_sp;
		logic [TIME_W-1:0]  avg_wt;
		logic [COUNT_W-1:0] count;
	} frame_timing_t;

	logic [TARGET_W-1:0] target_time;
	logic [TIME_W-1:0]   elapsed_ring [WINDOW];
	logic [TIME_W-1:0]   spent_ring [WINDOW];
	logic [TIME_W-1:0]   waiting_ring [WINDOW];
	logic [31:0]         elapsed_total;
	logic [31:0]         spent_total;
	logic [31:0]         waiting_total;
	logic [COUNT_W-1:0]  frames_done;
	logic                fps_seen;
	logic [TIME_W-1:0]   fps_held;
	logic [TIME_W-1:0]   avg_el_held;
	logic [TIME_W-1:0]   avg_sp_held;
	logic [TIME_W-1:0]   avg_wt_held;
	frame_timing_t       timing_queue [$];
	frame_timing_t       oldest;
	int                  fail_tally;
	int                  results_seen;

	// Advances the monitor state by one frame and returns the result it reports.
	function automatic frame_timing_t time_frame(input logic [TICK_W-1:0] t0,
			input logic [TICK_W-1:0] t1);
		frame_timing_t       r;
		logic [TICK_W-1:0]   ticks;
		logic [TIME_W-1:0]   spent;
		logic [TIME_W-1:0]   waiting;
		logic [TIME_W-1:0]   elapsed;
		logic [TIME_W-1:0]   avg;
		logic [31:0]         quot;
		int                  slot;

		ticks = t1 - t0;
		if (ticks > MS_MAX) begin
			ticks = MS_MAX;
		end
		spent = TIME_W'(ticks) << FRAC_W;
		waiting = '0;
		if (target_time != 0 && spent < target_time) begin
			waiting = target_time - spent;
		end
		elapsed = spent + waiting;

		slot = int'(frames_done % WINDOW);
		elapsed_total = elapsed_total - elapsed_ring[slot] + elapsed;
		spent_total = spent_total - spent_ring[slot] + spent;
		waiting_total = waiting_total - waiting_ring[slot] + waiting;
		elapsed_ring[slot] = elapsed;
		spent_ring[slot] = spent;
		waiting_ring[slot] = waiting;

		if (frames_done > WINDOW) begin
			avg = elapsed_total / WINDOW;
			if (avg == 0) begin
				fps_held = TIME_MAX;
			end else begin
				quot = FPS_NUM / avg;
				fps_held = (quot > TIME_MAX) ? TIME_MAX : quot[TIME_W-1:0];
			end
			fps_seen = 1'b1;
			// Averages are latched only when the ring wraps back to its first slot.
			if (slot == 0) begin
				avg_el_held = avg;
				avg_sp_held = spent_total / WINDOW;
				avg_wt_held = waiting_total / WINDOW;
			end
		end
		frames_done = frames_done + 1;

		r.spent = spent;
		r.waiting = waiting;
		r.elapsed = elapsed;
		r.delay = waiting[FRAC_W +: DELAY_W];
		r.fps_ok = fps_seen;
		r.fps = fps_seen ? fps_held : '0;
		r.avg_el = avg_el_held;
		r.avg_sp = avg_sp_held;
		r.avg_wt = avg_wt_held;
		r.count = frames_done;
		return r;
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_tally++;
			if (fail_tally <= 10) begin
				$display("result %0d: %s expected %0d (0x%0h), got %0d (0x%0h)",
					results_seen, field, want, want, got, got);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_time = TARGET_RESET;
			foreach (elapsed_ring[i]) begin
				elapsed_ring[i] = '0;
				spent_ring[i] = '0;
				waiting_ring[i] = '0;
			end
			elapsed_total = '0;
			spent_total = '0;
			waiting_total = '0;
			frames_done = '0;
			fps_seen = 1'b0;
			fps_held = '0;
			avg_el_held = '0;
			avg_sp_held = '0;
			avg_wt_held = '0;
			timing_queue.delete();
			fail_tally = 0;
			results_seen = 0;
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				target_time = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				timing_queue.push_back(time_frame(frame_start_tick, frame_end_tick));
			end
			if (out_valid && out_ready) begin
				if (timing_queue.size() == 0) begin
					fail_tally++;
					if (fail_tally <= 10) begin
						$display("result %0d arrived with no frame waiting for it",
							results_seen);
					end
				end else begin
					oldest = timing_queue.pop_front();
					check_field("spent_time", oldest.spent, spent_time);
					check_field("waiting_time", oldest.waiting, waiting_time);
					check_field("elapsed_time", oldest.elapsed, elapsed_time);
					check_field("delay_ms", oldest.delay, delay_ms);
					check_field("fps_valid", oldest.fps_ok, fps_valid);
					check_field("fps_rate", oldest.fps, fps_rate);
					check_field("avg_elapsed", oldest.avg_el, avg_elapsed);
					check_field("avg_spent", oldest.avg_sp, avg_spent);
					check_field("avg_waiting", oldest.avg_wt, avg_waiting);
					check_field("frame_count", oldest.count, frame_count);
				end
				results_seen++;
			end
			// Published with nonblocking updates so the stimulus side reads a stable value.
			mismatch_count <= fail_tally;
			outstanding <= timing_queue.size();
		end
	end

endmodule

// File: verif/tb.sv
// Top of the frame pacing and timing monitor testbench: clock, reset, frame and
// result traffic, target register phases, watchdog and verdict.
// Depends on fptm_pkg, frame_pacing_timing_monitor and fptm_checker.
module tb;
	import fptm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// The longest frame runs all four serial divisions for a 64-deep window;
	// the drain pause sits comfortably above that.
	localparam int DRAIN_CYCLES = 150;
	// No transaction for this many cycles means the block has hung.
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 9;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [TICK_W-1:0]   frame_start_tick = '0;
	logic [TICK_W-1:0]   frame_end_tick = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [TIME_W-1:0]   spent_time;
	logic [TIME_W-1:0]   waiting_time;
	logic [TIME_W-1:0]   elapsed_time;
	logic [DELAY_W-1:0]  delay_ms;
	logic                fps_valid;
	logic [TIME_W-1:0]   fps_rate;
	logic [TIME_W-1:0]   avg_elapsed;
	logic [TIME_W-1:0]   avg_spent;
	logic [TIME_W-1:0]   avg_waiting;
	logic [COUNT_W-1:0]  frame_count;
	logic                cfg_we = 1'b0;
	logic [TARGET_W-1:0] cfg_wdata = '0;
	int                  mismatch_count;
	int                  outstanding;
	int                  quiet_cycles = 0;
	bit                  tx_gappy = 1'b1;

	// Directed frames, run with the target left at its reset value (about 16.67 ms).
	// They cover a frame just under and just over the target, a zero-length frame,
	// the tick counter wrapping, the last unsaturated length, lengths that saturate
	// at 65535 ms, and alternating bit patterns on both tick fields.
	logic [TICK_W-1:0] corner_frames [0:13][0:1] = '{
		'{32'h0000_0000, 32'h0000_0000},
		'{32'h0000_0000, 32'h0000_0010},
		'{32'h0000_0000, 32'h0000_0011},
		'{32'h0000_0064, 32'h0000_0074},
		'{32'hFFFF_FFFF, 32'h0000_0000},
		'{32'hFFFF_FFF0, 32'h0000_0005},
		'{32'h0000_0000, 32'h0000_FFFF},
		'{32'h0000_0000, 32'h0001_0000},
		'{32'h0000_0000, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFE},
		'{32'hAAAA_AAAA, 32'h5555_5555},
		'{32'h5555_5555, 32'hAAAA_AAAA},
		'{32'h1234_5678, 32'h1234_5688}
	};

	// One target per phase; a negative entry asks for a random target. Phases marked
	// as zero runs send only zero-length frames, so that the whole window holds the
	// target itself: a zero target gives a zero average and saturated fps, targets of
	// 1 and 3 give quotients too large for 24 bits, and 4 gives the largest that fits.
	int phase_target [PHASES] = '{0, 1, 3, 4, 262143, 256000, 0, -1, 4267};
	bit phase_zero [PHASES]   = '{1, 1, 1, 1, 0, 0, 0, 0, 0};
	int phase_frames [PHASES] = '{80, 80, 80, 80, 105, 105, 105, 105, 105};

	frame_pacing_timing_monitor #(
		.WINDOW(64)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_start_tick(frame_start_tick),
		.frame_end_tick(frame_end_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.spent_time(spent_time),
		.waiting_time(waiting_time),
		.elapsed_time(elapsed_time),
		.delay_ms(delay_ms),
		.fps_valid(fps_valid),
		.fps_rate(fps_rate),
		.avg_elapsed(avg_elapsed),
		.avg_spent(avg_spent),
		.avg_waiting(avg_waiting),
		.frame_count(frame_count),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	fptm_checker #(
		.WINDOW(64)
	) timing_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.frame_start_tick(frame_start_tick),
		.frame_end_tick(frame_end_tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.spent_time(spent_time),
		.waiting_time(waiting_time),
		.elapsed_time(elapsed_time),
		.delay_ms(delay_ms),
		.fps_valid(fps_valid),
		.fps_rate(fps_rate),
		.avg_elapsed(avg_elapsed),
		.avg_spent(avg_spent),
		.avg_waiting(avg_waiting),
		.frame_count(frame_count),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offers one frame transaction after a random gap and holds it until accepted.
	// The valid is left high on return, so a back-to-back frame keeps it asserted
	// without a second assignment in the same step.
	task automatic offer_frame(input logic [TICK_W-1:0] t0, input logic [TICK_W-1:0] t1);
		int gap;

		gap = tx_gappy ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		frame_start_tick <= t0;
		frame_end_tick <= t1;
		do @(posedge clk); while (!(in_valid && in_ready));
	endtask

	// Frame lengths are mostly realistic, with runs at the 65535 ms saturation
	// point, arbitrary 32-bit differences, and lengths right around the target so
	// that the waiting time crosses zero. The start tick is fully random, which
	// toggles every tick bit and makes the end tick wrap now and then.
	task automatic offer_random_frame(input logic [TARGET_W-1:0] tgt, input bit zero_run);
		logic [TICK_W-1:0] t0;
		logic [TICK_W-1:0] span;
		int pick;

		t0 = $urandom;
		pick = $urandom_range(0, 99);
		if (zero_run || pick >= 95) begin
			span = '0;
		end else if (pick < 40) begin
			span = $urandom_range(0, 40);
		end else if (pick < 60) begin
			span = $urandom_range(0, 1100);
		end else if (pick < 72) begin
			span = $urandom_range(65530, 65540);
		end else if (pick < 82) begin
			span = $urandom;
		end else begin
			span = (tgt >> FRAC_W) - 1 + $urandom_range(0, 2);
		end
		offer_frame(t0, t0 + span);
	endtask

	// Stops offering frames, lets every result drain out, waits out the longest
	// frame the block could still be working on, then writes the target register.
	task automatic drain_and_set_target(input logic [TARGET_W-1:0] value);
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Frame side: directed frames first, then one phase of random frames per target.
	initial begin
		logic [TARGET_W-1:0] phase_value;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_frames[i]) begin
			offer_frame(corner_frames[i][0], corner_frames[i][1]);
		end

		for (int p = 0; p < PHASES; p++) begin
			if (phase_target[p] < 0) begin
				phase_value = TARGET_W'($urandom_range(0, 262143));
			end else begin
				phase_value = TARGET_W'(phase_target[p]);
			end
			drain_and_set_target(phase_value);
			// Roughly one phase in four runs with the frame side never pausing.
			tx_gappy = ($urandom_range(0, 3) != 0);
			repeat (phase_frames[p]) offer_random_frame(phase_value, phase_zero[p]);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("** frame_pacing_timing_monitor: PASSED **");
		end else begin
			$display("** frame_pacing_timing_monitor: FAILED **");
		end
		$finish;
	end

	// Result side: a random stall before each result transaction, switching now and
	// then between stalling and always-ready stretches. Ready is lowered only when a
	// stall follows, so an always-ready stretch keeps a single steady assignment.
	initial begin
		int stall;
		bit rx_gappy;

		rx_gappy = 1'b1;
		do @(posedge clk); while (!arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0) begin
				rx_gappy = !rx_gappy;
			end
			stall = rx_gappy ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Watchdog: any transaction on either channel, or a register write, restarts the
	// count of quiet cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("** frame_pacing_timing_monitor: FAILED **");
				$finish;
			end
		end
	end

endmodule
